FILE: hw/rtl/b2da_pkg.sv
package b2da_pkg;

  localparam int VALUE_WIDTH_DEF = 64;
  localparam int IN_WIDTH        = 64;
  localparam int CHAR_WIDTH      = 6;
  localparam int BCD_DIGIT_WIDTH = 4;

  localparam logic [CHAR_WIDTH-1:0] ASCII_ZERO = 6'd48;

  // floor(w * log10(2)) + 1, exact for 8..64 bits
  function automatic int num_digits(input int w);
    return ((w * 1233) >> 12) + 1;
  endfunction

endpackage

FILE: hw/rtl/b2da_dabble.sv
module b2da_dabble #(
  parameter int VALUE_WIDTH = 64,
  parameter int NDIG        = 20
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [VALUE_WIDTH-1:0] start_value,
  output logic                   busy,
  output logic                   done,
  input  logic                   take,
  output logic [NDIG*4-1:0]      bcd
);
  import b2da_pkg::*;

  localparam int CNT_W = $clog2(VALUE_WIDTH + 1);
  localparam int BCD_W = NDIG * BCD_DIGIT_WIDTH;

  logic [VALUE_WIDTH-1:0] val;
  logic [CNT_W-1:0]       cnt;
  logic [BCD_W-1:0]       adjusted;

  // add-3 correction on every digit that is 5 or more
  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      if (bcd[i*4 +: 4] >= 4'd5) begin
        adjusted[i*4 +: 4] = bcd[i*4 +: 4] + 4'd3;
      end else begin
        adjusted[i*4 +: 4] = bcd[i*4 +: 4];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == CNT_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end else if (take) begin
        done <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      val <= start_value;
      bcd <= '0;
      cnt <= CNT_W'(VALUE_WIDTH);
    end else if (busy) begin
      val <= {val[VALUE_WIDTH-2:0], 1'b0};
      bcd <= {adjusted[BCD_W-2:0], val[VALUE_WIDTH-1]};
      cnt <= cnt - CNT_W'(1);
    end
  end

endmodule

FILE: hw/rtl/b2da_emit.sv
module b2da_emit #(
  parameter int NDIG = 20
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              load,
  input  logic [NDIG*4-1:0]                 load_bcd,
  output logic                              active,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [b2da_pkg::CHAR_WIDTH-1:0]   digit_char,
  output logic                              is_last
);
  import b2da_pkg::*;

  localparam int POS_W = $clog2(NDIG + 1);
  localparam int BCD_W = NDIG * BCD_DIGIT_WIDTH;

  logic [BCD_W-1:0] bcd;
  logic [POS_W-1:0] pos;
  logic             started;
  logic [3:0]       top;
  logic             last_pos;
  logic             step;
  logic             emit;

  assign top      = bcd[BCD_W-1 -: 4];
  assign last_pos = (pos == POS_W'(1));
  assign step     = active && (!out_valid || !out_stall);
  assign emit     = step && (started || top != 4'd0 || last_pos);

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      started   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        active  <= 1'b1;
        started <= 1'b0;
      end else if (step) begin
        if (emit) begin
          started <= 1'b1;
        end
        if (last_pos) begin
          active <= 1'b0;
        end
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bcd <= load_bcd;
      pos <= POS_W'(NDIG);
    end else if (step) begin
      bcd <= {bcd[BCD_W-5:0], 4'd0};
      pos <= pos - POS_W'(1);
    end
    if (emit) begin
      digit_char <= ASCII_ZERO + {2'b00, top};
      is_last    <= last_pos;
    end
  end

endmodule

FILE: hw/rtl/binary_to_decimal_ascii.sv
// channel | signals                        | payload
// input   | in_valid, in_stall (out)       | value[63:0]
// output  | out_valid, out_stall (in)      | digit_char[5:0], is_last
//
// Conversion: one shift-and-correct step per value bit.
// Emission: one BCD digit per cycle unless out_stall holds it, leading
// zeros dropped; it overlaps the next conversion.
// A new value is accepted once the previous result has been handed to the emitter.
// rst clears all control; out_stall holds the output register and the digit shift.
module binary_to_decimal_ascii #(
  parameter int VALUE_WIDTH = b2da_pkg::VALUE_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [b2da_pkg::IN_WIDTH-1:0]     value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [b2da_pkg::CHAR_WIDTH-1:0]   digit_char,
  output logic                              is_last
);
  import b2da_pkg::*;

  localparam int NDIG = num_digits(VALUE_WIDTH);

  logic               conv_busy;
  logic               conv_done;
  logic               emit_active;
  logic               load;
  logic               start;
  logic [NDIG*4-1:0]  bcd;

  assign in_stall = conv_busy || conv_done;
  assign start    = in_valid && !in_stall;
  assign load     = conv_done && !emit_active;

  b2da_dabble #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .NDIG        (NDIG)
  ) u_dabble (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .start_value (value[VALUE_WIDTH-1:0]),
    .busy        (conv_busy),
    .done        (conv_done),
    .take        (load),
    .bcd         (bcd)
  );

  b2da_emit #(
    .NDIG (NDIG)
  ) u_emit (
    .clk        (clk),
    .rst        (rst),
    .load       (load),
    .load_bcd   (bcd),
    .active     (emit_active),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .digit_char (digit_char),
    .is_last    (is_last)
  );

  a_char_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (digit_char >= ASCII_ZERO && digit_char <= ASCII_ZERO + 6'd9))
    else $error("digit out of range");

  a_accept_blocks: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (in_stall && conv_busy))
    else $error("accepted item did not start conversion");

  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    load |=> (emit_active && !conv_done))
    else $error("handoff to emitter failed");

endmodule
